// ----- sv/avc_cfg_pkg.sv -----
// shared types and constants of the avc configuration record parser
package avc_cfg_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int LENSZ_W  = 2;
  localparam int NALSZ_W  = 3;
  localparam int SPSCNT_W = 5;
  localparam int ULEN_W   = 16;
  localparam int TDATA_W  = 64;
  localparam int TUSER_W  = 4;

  localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SPS_LEN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPS_PAY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PPS_CNT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PPS_LEN = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PPS_PAY = 3'd5;
  localparam logic [KIND_W-1:0] KIND_TRAIL   = 3'd6;

  typedef enum logic [13:0] {
    PH_VER     = 14'b00000000000001,
    PH_PROF    = 14'b00000000000010,
    PH_COMPAT  = 14'b00000000000100,
    PH_LEVEL   = 14'b00000000001000,
    PH_LENSZ   = 14'b00000000010000,
    PH_SPSCNT  = 14'b00000000100000,
    PH_SPS_HI  = 14'b00000001000000,
    PH_SPS_LO  = 14'b00000010000000,
    PH_SPS_PAY = 14'b00000100000000,
    PH_PPSCNT  = 14'b00001000000000,
    PH_PPS_HI  = 14'b00010000000000,
    PH_PPS_LO  = 14'b00100000000000,
    PH_PPS_PAY = 14'b01000000000000,
    PH_TRAIL   = 14'b10000000000000
  } phase_t;

endpackage

// ----- sv/avc_config_record_parser.sv -----
// avc decoder configuration record parser, one byte per transaction
//
// input channel: one record byte per transaction, in_tuser marks the version
// byte that (re)starts a record from any point of the walk.
// output channel: one transaction per input byte with the byte's class, the
// index of the current sps or pps, the byte itself and the header values
// captured so far; out_tlast marks the final byte of one parameter set and
// out_tuser[3] the byte that completes the whole record.
// each result is registered and appears in the cycle after its byte is taken.
// throughput: one byte per cycle unless the receiver stalls; the phase register
// and the length and set counters change once per byte, so nothing else limits it.
// the output register frees its slot in the same cycle it is taken, so in_tready
// only drops while a result waits and out_tready is low.
// reset: the walk sits in trailing state with all captured values at zero;
// bytes arriving before any start are classed as trailing.
// a stalled receiver holds the result steady and stops the input channel.
module avc_config_record_parser
  import avc_cfg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // [7:0] in_byte
  input  logic [BYTE_W-1:0]  in_tdata,
  // [0] start_record
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // [7:0] set_index, [15:8] out_byte, [23:16] config_version, [31:24] profile,
  // [39:32] compat_flags, [47:40] level, [50:48] nal_length_size,
  // [55:51] sps_count, [63:56] pps_count
  output logic [TDATA_W-1:0] out_tdata,
  // unit_last
  output logic               out_tlast,
  // [2:0] byte_kind, [3] record_done
  output logic [TUSER_W-1:0] out_tuser
);

  phase_t               phase_r, phase_nxt;
  logic [BYTE_W-1:0]    version_r, version_nxt;
  logic [BYTE_W-1:0]    profile_r, profile_nxt;
  logic [BYTE_W-1:0]    compat_r, compat_nxt;
  logic [BYTE_W-1:0]    level_r, level_nxt;
  logic [LENSZ_W-1:0]   lensz_r, lensz_nxt;
  logic [SPSCNT_W-1:0]  sps_cnt_r, sps_cnt_nxt;
  logic [BYTE_W-1:0]    pps_cnt_r, pps_cnt_nxt;
  logic [BYTE_W-1:0]    sets_left_r, sets_left_nxt;
  logic [BYTE_W-1:0]    index_r, index_nxt;
  logic [BYTE_W-1:0]    len_hi_r, len_hi_nxt;
  logic [ULEN_W-1:0]    bytes_left_r, bytes_left_nxt;

  logic                 out_valid_r;
  logic [TDATA_W-1:0]   out_data_r;
  logic                 out_last_r;
  logic [TUSER_W-1:0]   out_user_r;

  logic                 in_fire;
  logic [BYTE_W-1:0]    b;
  logic                 start;
  phase_t               cur_phase;
  logic [BYTE_W-1:0]    cur_version, cur_profile, cur_compat, cur_level;
  logic [LENSZ_W-1:0]   cur_lensz;
  logic [SPSCNT_W-1:0]  cur_sps_cnt;
  logic [BYTE_W-1:0]    cur_pps_cnt, cur_sets_left, cur_index, cur_len_hi;
  logic [ULEN_W-1:0]    cur_bytes_left;
  logic [ULEN_W-1:0]    full_len;
  logic [ULEN_W-1:0]    left_dec;
  logic [BYTE_W-1:0]    sets_dec;
  logic                 is_pps;
  logic [KIND_W-1:0]    kind;
  logic [BYTE_W-1:0]    idx;
  logic                 last;
  logic                 done;
  logic                 finish;
  logic [NALSZ_W-1:0]   nal_size;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign start     = in_tuser;

  // a start byte sees the walk as if freshly reset into the version phase
  always_comb begin
    cur_phase      = start ? PH_VER : phase_r;
    cur_version    = start ? '0 : version_r;
    cur_profile    = start ? '0 : profile_r;
    cur_compat     = start ? '0 : compat_r;
    cur_level      = start ? '0 : level_r;
    cur_lensz      = start ? '0 : lensz_r;
    cur_sps_cnt    = start ? '0 : sps_cnt_r;
    cur_pps_cnt    = start ? '0 : pps_cnt_r;
    cur_sets_left  = start ? '0 : sets_left_r;
    cur_index      = start ? '0 : index_r;
    cur_len_hi     = start ? '0 : len_hi_r;
    cur_bytes_left = start ? '0 : bytes_left_r;
  end

  assign full_len = {cur_len_hi, b};
  assign left_dec = cur_bytes_left - ULEN_W'(1);
  assign sets_dec = cur_sets_left - BYTE_W'(1);
  assign is_pps   = (cur_phase == PH_PPS_LO) || (cur_phase == PH_PPS_PAY);

  always_comb begin
    phase_nxt      = cur_phase;
    version_nxt    = cur_version;
    profile_nxt    = cur_profile;
    compat_nxt     = cur_compat;
    level_nxt      = cur_level;
    lensz_nxt      = cur_lensz;
    sps_cnt_nxt    = cur_sps_cnt;
    pps_cnt_nxt    = cur_pps_cnt;
    sets_left_nxt  = cur_sets_left;
    index_nxt      = cur_index;
    len_hi_nxt     = cur_len_hi;
    bytes_left_nxt = cur_bytes_left;
    kind           = KIND_TRAIL;
    idx            = '0;
    last           = 1'b0;
    done           = 1'b0;
    finish         = 1'b0;
    unique case (cur_phase)
      PH_VER: begin
        kind        = KIND_HEADER;
        version_nxt = b;
        phase_nxt   = PH_PROF;
      end
      PH_PROF: begin
        kind        = KIND_HEADER;
        profile_nxt = b;
        phase_nxt   = PH_COMPAT;
      end
      PH_COMPAT: begin
        kind       = KIND_HEADER;
        compat_nxt = b;
        phase_nxt  = PH_LEVEL;
      end
      PH_LEVEL: begin
        kind      = KIND_HEADER;
        level_nxt = b;
        phase_nxt = PH_LENSZ;
      end
      PH_LENSZ: begin
        kind      = KIND_HEADER;
        lensz_nxt = b[LENSZ_W-1:0];
        phase_nxt = PH_SPSCNT;
      end
      PH_SPSCNT: begin
        kind          = KIND_HEADER;
        sps_cnt_nxt   = b[SPSCNT_W-1:0];
        sets_left_nxt = BYTE_W'(b[SPSCNT_W-1:0]);
        index_nxt     = '0;
        phase_nxt     = (b[SPSCNT_W-1:0] == '0) ? PH_PPSCNT : PH_SPS_HI;
      end
      PH_SPS_HI: begin
        kind       = KIND_SPS_LEN;
        idx        = cur_index;
        len_hi_nxt = b;
        phase_nxt  = PH_SPS_LO;
      end
      PH_PPS_HI: begin
        kind       = KIND_PPS_LEN;
        idx        = cur_index;
        len_hi_nxt = b;
        phase_nxt  = PH_PPS_LO;
      end
      PH_SPS_LO, PH_PPS_LO: begin
        kind           = is_pps ? KIND_PPS_LEN : KIND_SPS_LEN;
        idx            = cur_index;
        bytes_left_nxt = full_len;
        if (full_len == '0) begin
          last   = 1'b1;
          finish = 1'b1;
        end else begin
          phase_nxt = is_pps ? PH_PPS_PAY : PH_SPS_PAY;
        end
      end
      PH_SPS_PAY, PH_PPS_PAY: begin
        kind           = is_pps ? KIND_PPS_PAY : KIND_SPS_PAY;
        idx            = cur_index;
        bytes_left_nxt = left_dec;
        if (left_dec == '0) begin
          last   = 1'b1;
          finish = 1'b1;
        end
      end
      PH_PPSCNT: begin
        kind          = KIND_PPS_CNT;
        pps_cnt_nxt   = b;
        sets_left_nxt = b;
        index_nxt     = '0;
        if (b == '0) begin
          phase_nxt = PH_TRAIL;
          done      = 1'b1;
        end else begin
          phase_nxt = PH_PPS_HI;
        end
      end
      default: begin
        kind      = KIND_TRAIL;
        phase_nxt = PH_TRAIL;
      end
    endcase

    // end of one parameter set: next set, pps count or record complete
    if (finish) begin
      index_nxt     = cur_index + BYTE_W'(1);
      sets_left_nxt = sets_dec;
      if (sets_dec == '0) begin
        if (is_pps) begin
          phase_nxt = PH_TRAIL;
          done      = 1'b1;
        end else begin
          phase_nxt = PH_PPSCNT;
        end
      end else begin
        phase_nxt = is_pps ? PH_PPS_HI : PH_SPS_HI;
      end
    end
  end

  assign nal_size = NALSZ_W'(lensz_nxt) + NALSZ_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TRAIL;
      version_r    <= '0;
      profile_r    <= '0;
      compat_r     <= '0;
      level_r      <= '0;
      lensz_r      <= '0;
      sps_cnt_r    <= '0;
      pps_cnt_r    <= '0;
      sets_left_r  <= '0;
      index_r      <= '0;
      len_hi_r     <= '0;
      bytes_left_r <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      version_r    <= version_nxt;
      profile_r    <= profile_nxt;
      compat_r     <= compat_nxt;
      level_r      <= level_nxt;
      lensz_r      <= lensz_nxt;
      sps_cnt_r    <= sps_cnt_nxt;
      pps_cnt_r    <= pps_cnt_nxt;
      sets_left_r  <= sets_left_nxt;
      index_r      <= index_nxt;
      len_hi_r     <= len_hi_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {pps_cnt_nxt, sps_cnt_nxt, nal_size, level_nxt, compat_nxt,
                     profile_nxt, version_nxt, b, idx};
      out_last_r <= last;
      out_user_r <= {done, kind};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule
